/* rtl/core/erc_pkg.sv */
// Shared types and constants for the EtherCAT reply checker.
// No dependencies; used by every file under rtl/core.
`default_nettype none

package erc_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd2;

	localparam int LEN_W = 11;

	// frame layout
	localparam logic [7:0] ETHERTYPE_HI = 8'h88;
	localparam logic [7:0] ETHERTYPE_LO = 8'hA4;
	localparam int POS_ETHERTYPE = 12;
	localparam int POS_COMMAND   = 16;
	localparam int POS_INDEX     = 17;
	localparam int POS_LENGTH    = 22;
	localparam int POS_DATA      = 26;

	// status codes
	localparam logic [2:0] ST_VALID     = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_ETHERTYPE = 3'd2;
	localparam logic [2:0] ST_IDENT     = 3'd3;
	localparam logic [2:0] ST_LENGTH    = 3'd4;
	localparam logic [2:0] ST_ZERO_WKC  = 3'd5;

	// result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// defaults for top-level parameters
	localparam int MAX_FRAME_BYTES_DEF = 4095;
	localparam int QUEUE_DEPTH_DEF     = 4;

	// one queue entry: the results caused by one received byte
	typedef struct packed {
		logic        has_data;
		logic [7:0]  data_byte;
		logic        has_status;
		logic [2:0]  status;
		logic [15:0] work_count;
	} erc_entry_t;

endpackage

`default_nettype wire

/* rtl/core/erc_front.sv */
// Front end of the EtherCAT reply checker: configuration registers, byte
// position tracking, header checks and counter capture. Uses erc_pkg.
`default_nettype none

module erc_front #(
	parameter int MAX_FRAME_BYTES = erc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [erc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [erc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic                            frame_end,
	input  wire logic                            q_full,
	output logic                                 q_push,
	output erc_pkg::erc_entry_t                  q_entry
);

	localparam int PosW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CmpW = ((PosW > 12) ? PosW : 12) + 1;

	logic [7:0]                exp_cmd_q;
	logic [7:0]                exp_idx_q;
	logic [erc_pkg::LEN_W-1:0] exp_len_q;

	logic [PosW-1:0] pos_q;
	logic            eth_bad_q;
	logic            ident_bad_q;
	logic            len_bad_q;
	logic [7:0]      held_q;
	logic [15:0]     wkc_q;
	logic            wkc_seen_q;

	logic                      accept;
	logic [CmpW-1:0]           p_c;
	logic [CmpW-1:0]           wkc_pos_c;
	logic                      in_range;
	logic [erc_pkg::LEN_W-1:0] len_word;
	logic                      eth_bad_n;
	logic                      ident_bad_n;
	logic                      len_bad_n;
	logic [7:0]                held_n;
	logic [15:0]               wkc_n;
	logic                      wkc_seen_n;
	logic                      is_data;
	logic [2:0]                status_c;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q <= '0;
			exp_idx_q <= '0;
			exp_len_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				erc_pkg::REG_COMMAND: exp_cmd_q <= cfg_data[7:0];
				erc_pkg::REG_INDEX:   exp_idx_q <= cfg_data[7:0];
				erc_pkg::REG_LENGTH:  exp_len_q <= cfg_data[erc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign p_c       = CmpW'(pos_q);
	assign wkc_pos_c = CmpW'(erc_pkg::POS_DATA) + CmpW'(exp_len_q);
	assign in_range  = p_c < CmpW'(MAX_FRAME_BYTES);
	assign len_word  = {rx_byte[2:0], held_q};

	always_comb begin
		eth_bad_n   = eth_bad_q;
		ident_bad_n = ident_bad_q;
		len_bad_n   = len_bad_q;
		held_n      = held_q;
		wkc_n       = wkc_q;
		wkc_seen_n  = wkc_seen_q;
		is_data     = 1'b0;
		if (in_range) begin
			if (p_c == CmpW'(erc_pkg::POS_ETHERTYPE) && rx_byte != erc_pkg::ETHERTYPE_HI)
				eth_bad_n = 1'b1;
			if (p_c == CmpW'(erc_pkg::POS_ETHERTYPE + 1) && rx_byte != erc_pkg::ETHERTYPE_LO)
				eth_bad_n = 1'b1;
			if (p_c == CmpW'(erc_pkg::POS_COMMAND) && rx_byte != exp_cmd_q)
				ident_bad_n = 1'b1;
			if (p_c == CmpW'(erc_pkg::POS_INDEX) && rx_byte != exp_idx_q)
				ident_bad_n = 1'b1;
			if (p_c == CmpW'(erc_pkg::POS_LENGTH + 1) && len_word != exp_len_q)
				len_bad_n = 1'b1;
			if (p_c == CmpW'(erc_pkg::POS_LENGTH) || p_c == wkc_pos_c)
				held_n = rx_byte;
			// header flags only change below the data start, so the held flags apply
			is_data = (p_c >= CmpW'(erc_pkg::POS_DATA)) && (p_c < wkc_pos_c) &&
				!eth_bad_q && !ident_bad_q && !len_bad_q;
			if (p_c == wkc_pos_c + CmpW'(1)) begin
				wkc_n      = {rx_byte, held_q};
				wkc_seen_n = 1'b1;
			end
		end
	end

	always_comb begin
		if (!wkc_seen_n)
			status_c = erc_pkg::ST_SHORT;
		else if (eth_bad_n)
			status_c = erc_pkg::ST_ETHERTYPE;
		else if (ident_bad_n)
			status_c = erc_pkg::ST_IDENT;
		else if (len_bad_n)
			status_c = erc_pkg::ST_LENGTH;
		else if (wkc_n == 16'd0)
			status_c = erc_pkg::ST_ZERO_WKC;
		else
			status_c = erc_pkg::ST_VALID;
	end

	// frame state; clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			eth_bad_q   <= 1'b0;
			ident_bad_q <= 1'b0;
			len_bad_q   <= 1'b0;
			held_q      <= '0;
			wkc_q       <= '0;
			wkc_seen_q  <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q       <= '0;
				eth_bad_q   <= 1'b0;
				ident_bad_q <= 1'b0;
				len_bad_q   <= 1'b0;
				held_q      <= '0;
				wkc_q       <= '0;
				wkc_seen_q  <= 1'b0;
			end else begin
				if (in_range)
					pos_q <= pos_q + PosW'(1);
				eth_bad_q   <= eth_bad_n;
				ident_bad_q <= ident_bad_n;
				len_bad_q   <= len_bad_n;
				held_q      <= held_n;
				wkc_q       <= wkc_n;
				wkc_seen_q  <= wkc_seen_n;
			end
		end
	end

	// push only bytes that cause a result
	assign q_push = accept && (is_data || frame_end);

	always_comb begin
		q_entry            = '0;
		q_entry.has_data   = is_data;
		q_entry.data_byte  = is_data ? rx_byte : 8'd0;
		q_entry.has_status = frame_end;
		q_entry.status     = frame_end ? status_c : 3'd0;
		q_entry.work_count = frame_end ? wkc_n : 16'd0;
	end

endmodule

`default_nettype wire

/* rtl/core/erc_fifo.sv */
// Short register queue between the checker front end and the result stage.
// Carries erc_pkg::erc_entry_t entries.
`default_nettype none

module erc_fifo #(
	parameter int DEPTH = erc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire erc_pkg::erc_entry_t push_entry,
	output logic                     full,
	input  wire logic                pop,
	output erc_pkg::erc_entry_t      pop_entry,
	output logic                     empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	erc_pkg::erc_entry_t mem_q [DEPTH];
	logic [AW-1:0]       wr_ptr_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;

	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

/* rtl/core/erc_back.sv */
// Result stage of the EtherCAT reply checker: drains queue entries, sends
// one result beat per cycle unless stalled, data before status. Uses erc_pkg.
`default_nettype none

module erc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  wire erc_pkg::erc_entry_t q_entry,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     kind,
	output logic [7:0]               data_byte,
	output logic [2:0]               status,
	output logic [15:0]              work_count
);

	logic        valid_q;
	logic        kind_q;
	logic [7:0]  data_q;
	logic [2:0]  status_q;
	logic [15:0] wkc_q;
	logic        pend_q;
	logic [2:0]  pend_status_q;
	logic [15:0] pend_wkc_q;
	logic        load;

	assign load  = !valid_q || out_ready;
	assign q_pop = load && !pend_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			kind_q  <= erc_pkg::KIND_DATA;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				kind_q  <= erc_pkg::KIND_STATUS;
				pend_q  <= 1'b0;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				kind_q  <= q_entry.has_data ? erc_pkg::KIND_DATA : erc_pkg::KIND_STATUS;
				// hold the status half back when the byte also carried data
				pend_q  <= q_entry.has_data && q_entry.has_status;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				data_q   <= 8'd0;
				status_q <= pend_status_q;
				wkc_q    <= pend_wkc_q;
			end else if (!q_empty) begin
				data_q        <= q_entry.data_byte;
				status_q      <= q_entry.has_data ? 3'd0 : q_entry.status;
				wkc_q         <= q_entry.has_data ? 16'd0 : q_entry.work_count;
				pend_status_q <= q_entry.status;
				pend_wkc_q    <= q_entry.work_count;
			end
		end
	end

	assign out_valid  = valid_q;
	assign kind       = kind_q;
	assign data_byte  = data_q;
	assign status     = status_q;
	assign work_count = wkc_q;

	a_pend_behind_data: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> valid_q && kind_q == erc_pkg::KIND_DATA)
		else $error("pending status without a data beat ahead of it");

	a_status_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && out_ready |=> valid_q && kind_q == erc_pkg::KIND_STATUS)
		else $error("pending status not sent after its data beat");

	a_no_pop_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !q_pop)
		else $error("queue popped while a status beat is pending");

endmodule

`default_nettype wire

/* rtl/core/ethercat_reply_checker.sv */
// EtherCAT datagram reply checker, top level.
// Ties erc_front, erc_fifo and erc_back together; uses erc_pkg.
//
// Usage: frame bytes enter on the in channel (in_valid/in_ready, rx_byte,
// frame_end marking the last byte), one byte per cycle unless stalled. Data
// bytes leave on the out channel as kind 0 beats while the EtherType,
// command, index and length checks pass; the final byte of a frame yields
// one kind 1 beat with status and the captured working counter.
// Configuration: cfg_wr_en/cfg_index/cfg_data write expected_command (0),
// expected_index (1) and expected_length (2). The user must write only
// while idle; the block does not enforce it. Path: an accepted byte is
// registered in the result queue, then in the output register. Rates: one
// byte per cycle in and one beat per cycle out while not stalled; a frame
// whose last byte is also data adds a status beat, absorbed by the queue.
// Reset: frame, config and queue state clear at once; no clearing pass.
// Stall: a stalled receiver holds its beat; the queue (QUEUE_DEPTH entries)
// fills and then in_ready drops until the receiver drains it.
`default_nettype none

module ethercat_reply_checker #(
	parameter int MAX_FRAME_BYTES = erc_pkg::MAX_FRAME_BYTES_DEF,
	parameter int QUEUE_DEPTH     = erc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [erc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [erc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic                            frame_end,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 kind,
	output logic [7:0]                           data_byte,
	output logic [2:0]                           status,
	output logic [15:0]                          work_count
);

	logic                q_push;
	logic                q_full;
	logic                q_pop;
	logic                q_empty;
	erc_pkg::erc_entry_t push_entry;
	erc_pkg::erc_entry_t pop_entry;

	erc_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	erc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	erc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_entry    (pop_entry),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.data_byte  (data_byte),
		.status     (status),
		.work_count (work_count)
	);

endmodule

`default_nettype wire
